// ===== hdl/cfzp_pkg.sv =====
// Shared constants, types and helper functions for the centered zero-padded FIR filter.
package cfzp_pkg;

  localparam int unsigned MAX_TAPS       = 7;
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_BITS      = 16;
  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned TAP_BITS       = 3;
  localparam int unsigned LAG_BITS       = 2;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned PROD_BITS      = SAMPLE_BITS + 1 + COEF_BITS;
  localparam int unsigned SUM_BITS       = PROD_BITS + 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_0    = 3'd1;

  localparam logic [TAP_BITS-1:0] SEEN_MAX = 3'd7;

  typedef logic [MAX_TAPS-1:0][SAMPLE_BITS-1:0] window_t;
  typedef logic [MAX_TAPS-1:0][COEF_BITS-1:0]   coef_arr_t;

  // Single-tap identity kernel: tap 0 is 1.0 in Q2.14, all others zero.
  localparam coef_arr_t COEF_RESET =
    {{((MAX_TAPS - 1) * COEF_BITS){1'b0}}, COEF_BITS'(1 << COEF_FRAC_BITS)};

  typedef struct packed {
    window_t ops;
    logic    last;
  } tap_req_t;

  function automatic logic [TAP_BITS-1:0] eff_taps(input logic [TAP_BITS-1:0] tap_count);
    eff_taps = (tap_count == '0) ? TAP_BITS'(1) : tap_count;
  endfunction

endpackage

// ===== hdl/cfzp_window.sv =====
// Delay line, sequence tracking and per-output tap operand selection.
module cfzp_window (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [cfzp_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic                                  seq_end_i,
  input  logic [cfzp_pkg::TAP_BITS-1:0]         taps_i,
  output logic                                  req_valid_o,
  input  logic                                  req_ready_i,
  output cfzp_pkg::tap_req_t                    req_o
);

  cfzp_pkg::window_t                    dl_q, dl_d;
  logic [cfzp_pkg::TAP_BITS-1:0]        seen_q, seen_d;
  logic                                 job_v_q, job_v_d;
  cfzp_pkg::window_t                    job_win_q;
  logic [cfzp_pkg::LAG_BITS-1:0]        job_e_q, job_e_d;
  logic [cfzp_pkg::TAP_BITS-1:0]        job_rem_q, job_rem_d;
  logic                                 job_end_q, job_end_d;

  cfzp_pkg::window_t                    shifted;
  logic [cfzp_pkg::TAP_BITS-1:0]        n;
  logic [cfzp_pkg::LAG_BITS-1:0]        lag;
  logic [cfzp_pkg::TAP_BITS-1:0]        lag_p1;
  logic [cfzp_pkg::TAP_BITS-1:0]        cnt;
  logic [cfzp_pkg::TAP_BITS-1:0]        half;
  logic [cfzp_pkg::TAP_BITS-1:0]        base;
  logic                                 in_fire;
  logic                                 job_fire;

  assign job_fire   = job_v_q && req_ready_i;
  assign in_ready_o = !job_v_q || (req_ready_i && (job_rem_q == cfzp_pkg::TAP_BITS'(1)));
  assign in_fire    = in_valid_i && in_ready_o;

  assign lag    = cfzp_pkg::LAG_BITS'((taps_i - cfzp_pkg::TAP_BITS'(1)) >> 1);
  assign lag_p1 = cfzp_pkg::TAP_BITS'({1'b0, lag}) + cfzp_pkg::TAP_BITS'(1);
  assign n      = (seen_q < cfzp_pkg::SEEN_MAX) ? seen_q + cfzp_pkg::TAP_BITS'(1) : seen_q;
  assign cnt    = (n < lag_p1) ? n : lag_p1;
  assign half   = taps_i >> 1;
  assign base   = cfzp_pkg::TAP_BITS'({1'b0, job_e_q}) + half;

  always_comb begin
    shifted[0] = sample_i;
    for (int i = 1; i < cfzp_pkg::MAX_TAPS; i++) begin
      shifted[i] = dl_q[i-1];
    end
  end

  always_comb begin
    dl_d      = dl_q;
    seen_d    = seen_q;
    job_v_d   = job_v_q;
    job_e_d   = job_e_q;
    job_rem_d = job_rem_q;
    job_end_d = job_end_q;
    if (in_fire) begin
      if (seq_end_i) begin
        dl_d      = '0;
        seen_d    = '0;
        job_v_d   = 1'b1;
        job_e_d   = cfzp_pkg::LAG_BITS'(cnt - cfzp_pkg::TAP_BITS'(1));
        job_rem_d = cnt;
        job_end_d = 1'b1;
      end else begin
        dl_d      = shifted;
        seen_d    = n;
        job_v_d   = (n - cfzp_pkg::TAP_BITS'(1)) >= cfzp_pkg::TAP_BITS'({1'b0, lag});
        job_e_d   = lag;
        job_rem_d = cfzp_pkg::TAP_BITS'(1);
        job_end_d = 1'b0;
      end
    end else if (job_fire) begin
      if (job_rem_q == cfzp_pkg::TAP_BITS'(1)) begin
        job_v_d = 1'b0;
      end else begin
        job_rem_d = job_rem_q - cfzp_pkg::TAP_BITS'(1);
        job_e_d   = job_e_q - cfzp_pkg::LAG_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_q      <= '0;
      seen_q    <= '0;
      job_v_q   <= 1'b0;
      job_e_q   <= '0;
      job_rem_q <= '0;
      job_end_q <= 1'b0;
    end else begin
      dl_q      <= dl_d;
      seen_q    <= seen_d;
      job_v_q   <= job_v_d;
      job_e_q   <= job_e_d;
      job_rem_q <= job_rem_d;
      job_end_q <= job_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_win_q <= shifted;
    end
  end

  // Tap v reads the sample that lies base - v places behind the newest one.
  always_comb begin
    req_o.last = job_end_q && (job_rem_q == cfzp_pkg::TAP_BITS'(1));
    for (int v = 0; v < cfzp_pkg::MAX_TAPS; v++) begin
      if ((cfzp_pkg::TAP_BITS'(v) < taps_i) && (cfzp_pkg::TAP_BITS'(v) <= base)) begin
        req_o.ops[v] = job_win_q[base - cfzp_pkg::TAP_BITS'(v)];
      end else begin
        req_o.ops[v] = '0;
      end
    end
  end

  assign req_valid_o = job_v_q;

endmodule

// ===== hdl/cfzp_mac.sv =====
// Parallel tap multipliers, adder tree, truncation and saturation, and the result register.
module cfzp_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  cfzp_pkg::tap_req_t                req_i,
  input  cfzp_pkg::coef_arr_t               coef_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cfzp_pkg::SAMPLE_BITS-1:0]  filtered_o,
  output logic                              out_last_o
);

  localparam int unsigned QUOT_BITS = cfzp_pkg::SUM_BITS - cfzp_pkg::COEF_FRAC_BITS;

  logic signed [cfzp_pkg::PROD_BITS-1:0] prod_q [cfzp_pkg::MAX_TAPS];
  logic                                  prod_v_q;
  logic                                  prod_last_q;
  logic                                  prod_adv;
  logic                                  out_adv;
  logic                                  out_v_q;
  logic [cfzp_pkg::SAMPLE_BITS-1:0]      filt_q, filt_d;
  logic                                  last_q;
  logic signed [cfzp_pkg::SUM_BITS-1:0]  acc;
  logic [QUOT_BITS-1:0]                  quot;

  assign out_adv     = !out_v_q || out_ready_i;
  assign prod_adv    = !prod_v_q || out_adv;
  assign req_ready_o = prod_adv;

  always_ff @(posedge clk_i) begin
    if (prod_adv && req_valid_i) begin
      for (int v = 0; v < cfzp_pkg::MAX_TAPS; v++) begin
        prod_q[v] <= $signed({1'b0, req_i.ops[v]}) * $signed(coef_i[v]);
      end
      prod_last_q <= req_i.last;
    end
  end

  // A negative sum truncates to a value below zero, which saturates to zero.
  always_comb begin
    acc = '0;
    for (int v = 0; v < cfzp_pkg::MAX_TAPS; v++) begin
      acc = acc + cfzp_pkg::SUM_BITS'(prod_q[v]);
    end
    quot = acc[cfzp_pkg::SUM_BITS-1:cfzp_pkg::COEF_FRAC_BITS];
    if (acc[cfzp_pkg::SUM_BITS-1]) begin
      filt_d = '0;
    end else if (|quot[QUOT_BITS-1:cfzp_pkg::SAMPLE_BITS]) begin
      filt_d = '1;
    end else begin
      filt_d = quot[cfzp_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && prod_v_q) begin
      filt_q <= filt_d;
      last_q <= prod_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (prod_adv) begin
        prod_v_q <= req_valid_i;
      end
      if (out_adv) begin
        out_v_q <= prod_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign filtered_o  = filt_q;
  assign out_last_o  = last_q;

endmodule

// ===== hdl/centered_fir_zero_padded_core.sv =====
// Top level of the centered zero-padded FIR filter with its configuration registers.
//
// Samples enter on the input channel (in_valid_i/in_ready_o, sample_i, seq_end_i) and
// filtered samples leave on the output channel (out_valid_o/out_ready_i, filtered_o,
// out_last_o). Each channel moves one item per transfer when valid and ready are high.
// With k taps, outputs lag the inputs by (k-1)/2 samples; the sample that carries
// seq_end_i flushes the remaining outputs, up to four, one per cycle unless the output
// stalls, and the last of them carries out_last_o. A new sample is taken in every cycle
// unless a flush is still being issued or the pipeline is stalled. An output passes from
// the operand register through the product register into the result register, where it
// waits until it is taken. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must do so only while the filter is idle, as the block does not
// enforce it. Index 0 is the tap count, indexes 1 to 7 the Q2.14 coefficients.
// Reset clears the delay line and selects the single-tap identity kernel. When the
// receiver stalls, the pipeline fills and in_ready_o drops; no item is lost.
module centered_fir_zero_padded_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [cfzp_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic                                  seq_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [cfzp_pkg::SAMPLE_BITS-1:0]      filtered_o,
  output logic                                  out_last_o,
  input  logic                                  cfg_we_i,
  input  logic [cfzp_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [cfzp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i
);

  logic [cfzp_pkg::TAP_BITS-1:0] tap_count_q;
  cfzp_pkg::coef_arr_t           coef_q;
  logic [cfzp_pkg::TAP_BITS-1:0] taps;
  logic                          req_valid;
  logic                          req_ready;
  cfzp_pkg::tap_req_t            req;
  logic [cfzp_pkg::TAP_BITS-1:0] coef_sel;

  assign coef_sel = cfg_idx_i - cfzp_pkg::REG_COEF_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= cfzp_pkg::TAP_BITS'(1);
      coef_q      <= cfzp_pkg::COEF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfzp_pkg::REG_TAP_COUNT: begin
          tap_count_q <= cfg_wdata_i[cfzp_pkg::TAP_BITS-1:0];
        end
        default: begin
          coef_q[coef_sel] <= cfg_wdata_i[cfzp_pkg::COEF_BITS-1:0];
        end
      endcase
    end
  end

  assign taps = cfzp_pkg::eff_taps(tap_count_q);

  cfzp_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .seq_end_i   (seq_end_i),
    .taps_i      (taps),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  cfzp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .coef_i      (coef_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filtered_o  (filtered_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the centered zero-padded FIR filter core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 400;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 205;
  localparam int CALM_TAIL     = 40;

  typedef logic [cfzp_pkg::SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t filtered;
    logic    last;
  } filt_out_t;

  typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                          kind;
    logic [cfzp_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [cfzp_pkg::CFG_DATA_BITS-1:0] data;
    logic                               last;
    bit                                 known;
    filt_out_t                          result;
  } plan_row_t;

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  sample_t                            sample_i    = '0;
  logic                               seq_end_i   = 1'b0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  sample_t                            filtered_o;
  logic                               out_last_o;
  logic                               cfg_we_i    = 1'b0;
  logic [cfzp_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [cfzp_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  logic [cfzp_pkg::TAP_BITS-1:0]         tap_sel = cfzp_pkg::TAP_BITS'(1);
  logic signed [cfzp_pkg::COEF_BITS-1:0] kernel [cfzp_pkg::MAX_TAPS] =
    '{0: 16'sd16384, default: '0};
  sample_t                               hist [cfzp_pkg::MAX_TAPS] = '{default: '0};
  int                                    hist_len = 0;
  filt_out_t                             filtered_due [$];
  plan_row_t                             plan [$];

  int idle_pct   = 0;
  int stall_left = 0;
  int quiet      = 0;
  int fails      = 0;

  centered_fir_zero_padded_core DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  function automatic void expect_filtered(filt_out_t item);
    filtered_due.insert(filtered_due.size(), item);
  endfunction

  function automatic sample_t window_sum(int k, int e);
    longint acc;
    int     m;
    acc = 0;
    for (int v = 0; v < k; v++) begin
      m = e + k / 2 - v;
      if (m >= 0 && m < int'(cfzp_pkg::MAX_TAPS)) begin
        acc += longint'(hist[m]) * longint'(kernel[v]);
      end
    end
    acc = acc / (longint'(1) << cfzp_pkg::COEF_FRAC_BITS);
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << cfzp_pkg::SAMPLE_BITS) - 1) begin
      acc = (longint'(1) << cfzp_pkg::SAMPLE_BITS) - 1;
    end
    return sample_t'(acc);
  endfunction

  // Advances the filter state by one accepted sample and, when keep is set, queues the outputs it releases.
  task automatic filter_transfer(input sample_t s, input logic last, input bit keep);
    int k;
    int lag;
    int cnt;
    k   = (tap_sel == '0) ? 1 : int'(tap_sel);
    lag = k - 1 - k / 2;
    for (int i = cfzp_pkg::MAX_TAPS - 1; i > 0; i--) begin
      hist[i] = hist[i-1];
    end
    hist[0] = s;
    if (hist_len < int'(cfzp_pkg::SEEN_MAX)) begin
      hist_len++;
    end
    if (!last) begin
      if (keep && hist_len - 1 >= lag) begin
        expect_filtered(filt_out_t'{window_sum(k, lag), 1'b0});
      end
    end else begin
      cnt = (hist_len < lag + 1) ? hist_len : lag + 1;
      for (int r = 0; r < cnt; r++) begin
        if (keep) begin
          expect_filtered(filt_out_t'{window_sum(k, cnt - 1 - r), r == cnt - 1});
        end
      end
      hist     = '{default: '0};
      hist_len = 0;
    end
  endtask

  task automatic offer_sample(input sample_t s, input logic last);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    seq_end_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [cfzp_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [cfzp_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == cfzp_pkg::REG_TAP_COUNT) begin
      tap_sel = data[cfzp_pkg::TAP_BITS-1:0];
    end else begin
      kernel[idx - cfzp_pkg::REG_COEF_0] = data;
    end
  endtask

  function automatic plan_row_t row_known(sample_t s, logic last, sample_t f, logic fl);
    return '{ROW_SAMPLE, '0, s, last, 1'b1, filt_out_t'{f, fl}};
  endfunction

  function automatic plan_row_t row_free(sample_t s, logic last);
    return '{ROW_SAMPLE, '0, s, last, 1'b0, filt_out_t'{'0, 1'b0}};
  endfunction

  function automatic plan_row_t row_reg(logic [cfzp_pkg::CFG_IDX_BITS-1:0] idx,
                                        logic [cfzp_pkg::CFG_DATA_BITS-1:0] data);
    return '{ROW_REG, idx, data, 1'b0, 1'b0, filt_out_t'{'0, 1'b0}};
  endfunction

  always @(posedge clk_i) begin : out_check
    filt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_due.size() == 0) begin
        $error("filtered: expected nothing, actual %0d", filtered_o);
        fails++;
      end else begin
        want = filtered_due.pop_front();
        if (filtered_o !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, filtered_o);
          fails++;
        end
        if (out_last_o !== want.last) begin
          $error("out_last: expected %0d, actual %0d", want.last, out_last_o);
          fails++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    bit          writing;
    int          sent;
    int          nseq;
    int          len;
    int          cmode;
    bit          open_end;
    logic        last;
    sample_t     s;
    logic [15:0] cv;

    // Identity kernel after reset: every output equals its input.
    add_row(row_known(16'h0000, 1'b0, 16'h0000, 1'b0));
    add_row(row_known(16'hFFFF, 1'b0, 16'hFFFF, 1'b0));
    add_row(row_known(16'h0001, 1'b0, 16'h0001, 1'b0));
    add_row(row_known(16'h8000, 1'b0, 16'h8000, 1'b0));
    add_row(row_known(16'h5555, 1'b0, 16'h5555, 1'b0));
    add_row(row_known(16'hAAAA, 1'b1, 16'hAAAA, 1'b1));
    add_row(row_known(16'h1234, 1'b1, 16'h1234, 1'b1));
    // A tap count of zero acts as one tap; the gain of almost two saturates and truncates.
    add_row(row_reg(cfzp_pkg::REG_TAP_COUNT, 16'd0));
    add_row(row_reg(cfzp_pkg::REG_COEF_0, 16'h7FFF));
    add_row(row_known(16'd40000, 1'b1, 16'hFFFF, 1'b1));
    add_row(row_known(16'd3, 1'b1, 16'd5, 1'b1));
    add_row(row_reg(cfzp_pkg::REG_TAP_COUNT, 16'd7));
    add_row(row_reg(cfzp_pkg::REG_COEF_0, 16'h8000));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd1, 16'h7FFF));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd2, 16'h4000));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd3, 16'hC000));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd4, 16'h2000));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd5, 16'h0001));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd6, 16'hFFFF));
    add_row(row_free(16'hFFFF, 1'b0));
    add_row(row_free(16'h0000, 1'b0));
    add_row(row_free(16'hFFFF, 1'b0));
    add_row(row_free(16'h0001, 1'b0));
    add_row(row_free(16'hFFFF, 1'b0));
    add_row(row_free(16'h012C, 1'b0));
    add_row(row_free(16'h0007, 1'b0));
    add_row(row_free(16'h0009, 1'b0));
    add_row(row_free(16'hFFFF, 1'b1));
    // A sequence shorter than the lag flushes only the samples it has.
    add_row(row_free(16'h0064, 1'b0));
    add_row(row_free(16'h00C8, 1'b1));
    add_row(row_reg(cfzp_pkg::REG_TAP_COUNT, 16'd2));
    add_row(row_reg(cfzp_pkg::REG_COEF_0, 16'h4000));
    add_row(row_reg(cfzp_pkg::REG_COEF_0 + 3'd1, 16'h4000));
    add_row(row_free(16'hFFFF, 1'b0));
    add_row(row_free(16'hFFFF, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        reg_write(plan[i].idx, plan[i].data);
      end else begin
        if (writing) begin
          cfg_we_i <= 1'b0;
          writing = 1'b0;
        end
        offer_sample(plan[i].data, plan[i].last);
        filter_transfer(plan[i].data, plan[i].last, !plan[i].known);
        if (plan[i].known) begin
          expect_filtered(plan[i].result);
        end
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      reg_write(cfzp_pkg::REG_TAP_COUNT, cfzp_pkg::CFG_DATA_BITS'($urandom_range(0, 7)));
      cmode = $urandom_range(0, 3);
      for (int c = 0; c < int'(cfzp_pkg::MAX_TAPS); c++) begin
        if ($urandom_range(0, 1) == 1) begin
          case (cmode)
            0: cv = 16'($urandom);
            1: cv = 16'($urandom_range(0, 14000) - 4000);
            2: begin
              case ($urandom_range(0, 3))
                0: cv = 16'h8000;
                1: cv = 16'h7FFF;
                2: cv = 16'h0000;
                default: cv = 16'h4000;
              endcase
            end
            default: cv = 16'($urandom_range(0, 6000));
          endcase
          reg_write(cfzp_pkg::REG_COEF_0 + cfzp_pkg::CFG_IDX_BITS'(c), cv);
        end
      end
      cfg_we_i <= 1'b0;

      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 40;
      endcase
      if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
        idle_pct = 0;
      end

      nseq = $urandom_range(1, 3);
      for (int q = 0; q < nseq; q++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 8);
        open_end = (q == nseq - 1) && ($urandom_range(0, 5) == 0);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 9))
            0: s = '0;
            1: s = '1;
            2, 3: s = sample_t'($urandom_range(0, 255));
            default: s = sample_t'($urandom);
          endcase
          last = (j == len - 1) && !open_end;
          offer_sample(s, last);
          filter_transfer(s, last, 1'b1);
          sent++;
          if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
            idle_pct = 0;
          end
        end
      end
    end

    settle();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== centered_fir_zero_padded_core.f =====
hdl/cfzp_pkg.sv
hdl/cfzp_window.sv
hdl/cfzp_mac.sv
hdl/centered_fir_zero_padded_core.sv
dv/testbench.sv
